### rtl/amep_pkg.sv
package amep_pkg;

    // Field widths.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 29;
    localparam int HEAD_W    = 19;
    localparam int CURV_W    = 18;
    localparam int LEN_W     = 23;

    // Internal angle and CORDIC widths (angles in Q32 radians, sin/cos in Q30).
    localparam int ANG_W        = 44;
    localparam int Z_W          = 36;
    localparam int XY_W         = 33;
    localparam int CORDIC_STEPS = 32;
    localparam int WRAP_STEPS   = 8;
    localparam int TRIG_FRAC    = 30;
    localparam int HEAD_SHIFT   = 32 - FRAC_BITS;
    localparam int NUM_SHIFT    = 2 * FRAC_BITS - TRIG_FRAC;

    // Divider widths.
    localparam int NUM_W     = 35;
    localparam int DVD_W     = NUM_W + 1;
    localparam int QUO_W     = DVD_W + 1;
    localparam int DIV_STEPS = DVD_W;

    // Pipeline depths of the two units.
    localparam int SC_LAT  = 1 + WRAP_STEPS + 1 + CORDIC_STEPS + 1;
    localparam int DIV_LAT = 1 + DIV_STEPS + 1;

    // Angle constants in Q32 radians.
    // The offset is pi plus 128 turns, so that any input angle (at most about 42 turns
    // either way) lands in [0, 256 turns) before the binary reduction.
    localparam logic signed [Z_W-1:0] PI_Q32      = 36'sd13493037705;
    localparam logic signed [Z_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic [ANG_W-1:0]      TWO_PI_Q32  = 44'd26986075409;
    localparam logic [ANG_W-1:0]      WRAP_OFFSET =
        44'd13493037705 + (44'd26986075409 << (WRAP_STEPS - 1));
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Bound on the wrapped heading magnitude after rounding to the output format.
    localparam logic signed [HEAD_W-1:0] HEAD_PI_Q = 19'sd205888;

    // Arctangent of 2^-idx in Q32 radians.
    function automatic logic signed [Z_W-1:0] atan_q32(input int idx);
        logic signed [Z_W-1:0] r;
        unique case (idx)
            0:       r = 36'sd3373259426;
            1:       r = 36'sd1991351318;
            2:       r = 36'sd1052175346;
            3:       r = 36'sd534100635;
            4:       r = 36'sd268086748;
            5:       r = 36'sd134174063;
            6:       r = 36'sd67103403;
            7:       r = 36'sd33553749;
            8:       r = 36'sd16777131;
            9:       r = 36'sd8388597;
            10:      r = 36'sd4194303;
            default: r = Z_W'(longint'(1) << (32 - idx));
        endcase
        return r;
    endfunction

endpackage

### rtl/amep_sincos.sv
module amep_sincos (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [amep_pkg::ANG_W-1:0]    angle,
    output logic                                 out_valid,
    output logic signed [amep_pkg::Z_W-1:0]      wrapped,
    output logic signed [amep_pkg::XY_W-1:0]     cos_q30,
    output logic signed [amep_pkg::XY_W-1:0]     sin_q30
);

    localparam int WS   = amep_pkg::WRAP_STEPS;
    localparam int CS   = amep_pkg::CORDIC_STEPS;
    localparam int AW   = amep_pkg::ANG_W;
    localparam int ZW   = amep_pkg::Z_W;
    localparam int XYW  = amep_pkg::XY_W;

    logic [AW-1:0]         m_reg  [0:WS];
    logic                  wv_reg [0:WS];
    logic signed [ZW-1:0]  z_reg  [0:CS];
    logic signed [ZW-1:0]  wr_reg [0:CS];
    logic signed [XYW-1:0] x_reg  [0:CS];
    logic signed [XYW-1:0] y_reg  [0:CS];
    logic                  fl_reg [0:CS];
    logic                  cv_reg [0:CS];
    logic signed [ZW-1:0]  z0_next;
    logic signed [ZW-1:0]  zf_next;
    logic                  fl_next;
    logic                  ov_reg;
    logic signed [ZW-1:0]  wo_reg;
    logic signed [XYW-1:0] co_reg;
    logic signed [XYW-1:0] so_reg;

    // Shift the angle so that it is nonnegative before the reduction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg[0] <= 1'b0;
        end
        else
        begin
            wv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= $unsigned(angle) + amep_pkg::WRAP_OFFSET;
    end

    // Reduce modulo 2pi, one binary multiple of 2pi per stage.
    for (genvar j = 1; j <= WS; j++)
    begin : g_wrap
        localparam logic [AW-1:0] SUB = amep_pkg::TWO_PI_Q32 << (WS - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                wv_reg[j] <= 1'b0;
            end
            else
            begin
                wv_reg[j] <= wv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[j] <= (m_reg[j-1] >= SUB) ? (m_reg[j-1] - SUB) : m_reg[j-1];
        end
    end

    // Center into [-pi, pi) and fold into [-pi/2, pi/2] with a sign flip.
    always_comb
    begin
        z0_next = $signed({1'b0, m_reg[WS][ZW-2:0]}) - amep_pkg::PI_Q32;
        fl_next = 1'b0;
        zf_next = z0_next;
        if (z0_next > amep_pkg::HALF_PI_Q32)
        begin
            zf_next = z0_next - amep_pkg::PI_Q32;
            fl_next = 1'b1;
        end
        else if (z0_next < -amep_pkg::HALF_PI_Q32)
        begin
            zf_next = z0_next + amep_pkg::PI_Q32;
            fl_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= wv_reg[WS];
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg[0]  <= zf_next;
        wr_reg[0] <= z0_next;
        fl_reg[0] <= fl_next;
        x_reg[0]  <= amep_pkg::CORDIC_GAIN;
        y_reg[0]  <= '0;
    end

    // Rotation CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = amep_pkg::atan_q32(i);
        logic signed [XYW-1:0] xs;
        logic signed [XYW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            fl_reg[i+1] <= fl_reg[i];
            wr_reg[i+1] <= wr_reg[i];
        end
    end

    // Undo the fold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= cv_reg[CS];
        end
    end

    always_ff @(posedge clk)
    begin
        co_reg <= fl_reg[CS] ? -x_reg[CS] : x_reg[CS];
        so_reg <= fl_reg[CS] ? -y_reg[CS] : y_reg[CS];
        wo_reg <= wr_reg[CS];
    end

    assign out_valid = ov_reg;
    assign wrapped   = wo_reg;
    assign cos_q30   = co_reg;
    assign sin_q30   = so_reg;

endmodule

### rtl/amep_div.sv
module amep_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [amep_pkg::NUM_W-1:0]    num,
    input  logic signed [amep_pkg::CURV_W-1:0]   den,
    output logic                                 out_valid,
    output logic signed [amep_pkg::QUO_W-1:0]    quot
);

    localparam int NS  = amep_pkg::DIV_STEPS;
    localparam int DW  = amep_pkg::DVD_W;
    localparam int KW  = amep_pkg::CURV_W;
    localparam int NW  = amep_pkg::NUM_W;
    localparam int QW  = amep_pkg::QUO_W;

    logic [DW-1:0] qd_reg  [0:NS];
    logic [KW-1:0] rem_reg [0:NS];
    logic [KW-1:0] ad_reg  [0:NS];
    logic          neg_reg [0:NS];
    logic          v_reg   [0:NS];
    logic [NW-1:0] an_next;
    logic [KW-1:0] ad_next;
    logic          ov_reg;
    logic signed [QW-1:0] q_reg;

    // Magnitudes, with half the divisor added for round to nearest.
    always_comb
    begin
        an_next = num[NW-1] ? $unsigned(-num) : $unsigned(num);
        ad_next = den[KW-1] ? $unsigned(-den) : $unsigned(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg[0]  <= DW'(an_next) + DW'(ad_next >> 1);
        rem_reg[0] <= '0;
        ad_reg[0]  <= ad_next;
        neg_reg[0] <= num[NW-1] ^ den[KW-1];
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 1; j <= NS; j++)
    begin : g_step
        logic [KW:0] t;
        logic        ge;

        assign t  = {rem_reg[j-1], qd_reg[j-1][DW-1]};
        assign ge = (t >= {1'b0, ad_reg[j-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? KW'(t - {1'b0, ad_reg[j-1]}) : t[KW-1:0];
            qd_reg[j]  <= {qd_reg[j-1][DW-2:0], ge};
            ad_reg[j]  <= ad_reg[j-1];
            neg_reg[j] <= neg_reg[j-1];
        end
    end

    // Apply the sign of the quotient.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= neg_reg[NS] ? -$signed({1'b0, qd_reg[NS]}) : $signed({1'b0, qd_reg[NS]});
    end

    assign out_valid = ov_reg;
    assign quot      = q_reg;

endmodule

### rtl/arc_motion_end_pose.sv
// Throughput: one request per cycle; busy stays low, start is always taken.
// The depth is set by the 32-stage sine/cosine CORDIC and the divider's 36 restoring steps.
// Each result is shown for one cycle with done high; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers keep junk.
module arc_motion_end_pose (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [amep_pkg::COORD_W-1:0]   start_x,
    input  logic signed [amep_pkg::COORD_W-1:0]   start_y,
    input  logic signed [amep_pkg::HEAD_W-1:0]    start_heading,
    input  logic signed [amep_pkg::CURV_W-1:0]    path_curvature,
    input  logic        [amep_pkg::LEN_W-1:0]     arc_length,
    output logic                                  done,
    output logic signed [amep_pkg::COORD_W-1:0]   end_x,
    output logic signed [amep_pkg::COORD_W-1:0]   end_y,
    output logic signed [amep_pkg::HEAD_W-1:0]    end_heading,
    output logic                                  out_of_range
);

    localparam int CW    = amep_pkg::COORD_W;
    localparam int HW    = amep_pkg::HEAD_W;
    localparam int KW    = amep_pkg::CURV_W;
    localparam int LW    = amep_pkg::LEN_W;
    localparam int AW    = amep_pkg::ANG_W;
    localparam int ZW    = amep_pkg::Z_W;
    localparam int XYW   = amep_pkg::XY_W;
    localparam int NW    = amep_pkg::NUM_W;
    localparam int DXW   = amep_pkg::QUO_W;
    localparam int SUMW  = DXW + 1;
    localparam int PRODW = LW + 1 + KW;
    localparam int SPW   = LW + 1 + XYW;
    localparam int SCL   = amep_pkg::SC_LAT;
    localparam int DVL   = amep_pkg::DIV_LAT;

    localparam logic signed [CW-1:0]  COORD_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]  COORD_LO = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SPW-1:0] SP_HALF  =
        SPW'(longint'(1) << (amep_pkg::TRIG_FRAC - 1));
    localparam logic signed [ZW-1:0]  HD_HALF  =
        ZW'(longint'(1) << (amep_pkg::HEAD_SHIFT - 1));

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [HW-1:0] h;
        logic signed [KW-1:0] k;
        logic        [LW-1:0] len;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [HW-1:0]  h;
        logic signed [HW-1:0]  head_arc;
        logic                  straight;
        logic signed [SPW-1:0] spx;
        logic signed [SPW-1:0] spy;
    } mid_t;

    // Input capture.
    logic                    v0_reg;
    side_t                   s0_reg;
    // Swept angle product.
    logic                    v1_reg;
    side_t                   s1_reg;
    logic signed [PRODW-1:0] prod1_reg;
    logic signed [AW-1:0]    h32_1_reg;
    // Angles into the sine/cosine units.
    logic                    v2_reg;
    logic signed [AW-1:0]    ang_e_reg;
    logic signed [AW-1:0]    ang_h_reg;
    side_t                   sd_reg [0:SCL];
    // Sine/cosine results.
    logic                    sch_valid;
    logic                    sce_valid;
    logic signed [ZW-1:0]    we;
    logic signed [XYW-1:0]   ch;
    logic signed [XYW-1:0]   sh;
    logic signed [XYW-1:0]   ce;
    logic signed [XYW-1:0]   se;
    // Numerators and straight-line products.
    logic                    vm_reg;
    logic signed [NW-1:0]    numx_reg;
    logic signed [NW-1:0]    numy_reg;
    logic signed [KW-1:0]    km_reg;
    mid_t                    dd_reg [0:DVL];
    side_t                   sm;
    // Quotients.
    logic                    dvx_valid;
    logic                    dvy_valid;
    logic signed [DXW-1:0]   qx;
    logic signed [DXW-1:0]   qy;
    mid_t                    dm;
    logic signed [SPW-1:0]   rndx_next;
    logic signed [SPW-1:0]   rndy_next;
    // Offsets selected.
    logic                    vr_reg;
    logic                    arc_r_reg;
    logic signed [DXW-1:0]   dx_reg;
    logic signed [DXW-1:0]   dy_reg;
    logic signed [CW-1:0]    xr_reg;
    logic signed [CW-1:0]    yr_reg;
    logic signed [HW-1:0]    hr_reg;
    // Sums.
    logic                    vs_reg;
    logic signed [SUMW-1:0]  sumx_reg;
    logic signed [SUMW-1:0]  sumy_reg;
    logic signed [HW-1:0]    hs_reg;
    // Result registers.
    logic                    done_reg;
    logic signed [CW-1:0]    end_x_reg;
    logic signed [CW-1:0]    end_y_reg;
    logic signed [HW-1:0]    end_heading_reg;
    logic                    oor_reg;
    logic signed [CW-1:0]    end_x_next;
    logic signed [CW-1:0]    end_y_next;
    logic                    oor_next;

    // Every request is taken at once.
    assign busy = 1'b0;

    // Valid bits of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            vr_reg   <= 1'b0;
            vs_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            vm_reg   <= sce_valid;
            vr_reg   <= dvx_valid;
            vs_reg   <= vr_reg;
            done_reg <= vs_reg;
        end
    end

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_reg.x   <= start_x;
            s0_reg.y   <= start_y;
            s0_reg.h   <= start_heading;
            s0_reg.k   <= path_curvature;
            s0_reg.len <= arc_length;
        end
    end

    // Swept angle L*k, which is already Q32, and the heading in Q32.
    always_ff @(posedge clk)
    begin
        s1_reg    <= s0_reg;
        prod1_reg <= $signed({1'b0, s0_reg.len}) * s0_reg.k;
        h32_1_reg <= {{(AW - HW - amep_pkg::FRAC_BITS){s0_reg.h[HW-1]}}, s0_reg.h,
                      {amep_pkg::FRAC_BITS{1'b0}}};
    end

    // End angle before wrapping; the sideband enters its delay line here.
    always_ff @(posedge clk)
    begin
        ang_e_reg <= h32_1_reg + AW'(prod1_reg);
        ang_h_reg <= h32_1_reg;
        sd_reg[0] <= s1_reg;
    end

    for (genvar n = 1; n <= SCL; n++)
    begin : g_sd
        always_ff @(posedge clk)
        begin
            sd_reg[n] <= sd_reg[n-1];
        end
    end

    amep_sincos u_sc_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .angle     (ang_h_reg),
        .out_valid (sch_valid),
        .wrapped   (),
        .cos_q30   (ch),
        .sin_q30   (sh)
    );

    amep_sincos u_sc_end (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .angle     (ang_e_reg),
        .out_valid (sce_valid),
        .wrapped   (we),
        .cos_q30   (ce),
        .sin_q30   (se)
    );

    assign sm = sd_reg[SCL];

    // Chord numerators, straight-line products and the rounded arc heading.
    always_ff @(posedge clk)
    begin
        numx_reg           <= (NW'(se) - NW'(sh)) <<< amep_pkg::NUM_SHIFT;
        numy_reg           <= (NW'(ch) - NW'(ce)) <<< amep_pkg::NUM_SHIFT;
        km_reg             <= sm.k;
        dd_reg[0].x        <= sm.x;
        dd_reg[0].y        <= sm.y;
        dd_reg[0].h        <= sm.h;
        dd_reg[0].head_arc <= HW'((we + HD_HALF) >>> amep_pkg::HEAD_SHIFT);
        dd_reg[0].straight <= (sm.k == '0);
        dd_reg[0].spx      <= $signed({1'b0, sm.len}) * ch;
        dd_reg[0].spy      <= $signed({1'b0, sm.len}) * sh;
    end

    for (genvar n = 1; n <= DVL; n++)
    begin : g_dd
        always_ff @(posedge clk)
        begin
            dd_reg[n] <= dd_reg[n-1];
        end
    end

    amep_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vm_reg),
        .num       (numx_reg),
        .den       (km_reg),
        .out_valid (dvx_valid),
        .quot      (qx)
    );

    amep_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vm_reg),
        .num       (numy_reg),
        .den       (km_reg),
        .out_valid (dvy_valid),
        .quot      (qy)
    );

    assign dm = dd_reg[DVL];

    // Straight-line offsets rounded half up from Q30.
    always_comb
    begin
        rndx_next = (dm.spx + SP_HALF) >>> amep_pkg::TRIG_FRAC;
        rndy_next = (dm.spy + SP_HALF) >>> amep_pkg::TRIG_FRAC;
    end

    // Pick the offsets and heading for straight or arc motion.
    always_ff @(posedge clk)
    begin
        dx_reg    <= dm.straight ? DXW'(rndx_next) : qx;
        dy_reg    <= dm.straight ? DXW'(rndy_next) : qy;
        hr_reg    <= dm.straight ? dm.h : dm.head_arc;
        arc_r_reg <= !dm.straight;
        xr_reg    <= dm.x;
        yr_reg    <= dm.y;
    end

    // Add the offsets to the start position.
    always_ff @(posedge clk)
    begin
        sumx_reg <= SUMW'(xr_reg) + SUMW'(dx_reg);
        sumy_reg <= SUMW'(yr_reg) + SUMW'(dy_reg);
        hs_reg   <= hr_reg;
    end

    // Clamp each coordinate to its range and flag a clamp.
    always_comb
    begin
        oor_next   = 1'b0;
        end_x_next = CW'(sumx_reg);
        end_y_next = CW'(sumy_reg);
        if (sumx_reg > SUMW'(COORD_HI))
        begin
            end_x_next = COORD_HI;
            oor_next   = 1'b1;
        end
        else if (sumx_reg < SUMW'(COORD_LO))
        begin
            end_x_next = COORD_LO;
            oor_next   = 1'b1;
        end
        if (sumy_reg > SUMW'(COORD_HI))
        begin
            end_y_next = COORD_HI;
            oor_next   = 1'b1;
        end
        else if (sumy_reg < SUMW'(COORD_LO))
        begin
            end_y_next = COORD_LO;
            oor_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        end_x_reg       <= end_x_next;
        end_y_reg       <= end_y_next;
        end_heading_reg <= hs_reg;
        oor_reg         <= oor_next;
    end

    assign done         = done_reg;
    assign end_x        = end_x_reg;
    assign end_y        = end_y_reg;
    assign end_heading  = end_heading_reg;
    assign out_of_range = oor_reg;

    // The two sine/cosine pipelines run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n) sch_valid == sce_valid)
        else $error("sine/cosine pipelines out of step");

    // The two dividers run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n) dvx_valid == dvy_valid)
        else $error("divider pipelines out of step");

    // An arc heading is always wrapped into range.
    assert property (@(posedge clk) disable iff (!rst_n)
        vr_reg && arc_r_reg |-> (hr_reg >= -amep_pkg::HEAD_PI_Q) &&
                                (hr_reg <= amep_pkg::HEAD_PI_Q))
        else $error("arc heading not wrapped");

    // A raised range flag comes with a coordinate at a limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && oor_reg |-> (end_x_reg == COORD_HI) || (end_x_reg == COORD_LO) ||
                                (end_y_reg == COORD_HI) || (end_y_reg == COORD_LO))
        else $error("range flag without a clamped coordinate");

endmodule

### bench/tb_arc_motion_end_pose.sv
`timescale 1ns / 100ps

module tb_arc_motion_end_pose;

    localparam int COORD_W = amep_pkg::COORD_W;
    localparam int HEAD_W  = amep_pkg::HEAD_W;
    localparam int CURV_W  = amep_pkg::CURV_W;
    localparam int LEN_W   = amep_pkg::LEN_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  heading;
        logic signed [CURV_W-1:0]  curvature;
        logic        [LEN_W-1:0]   length;
    } pose_request_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  heading;
        logic                      clipped;
    } end_pose_t;

    typedef struct packed {
        pose_request_t req;
        logic          typed;
        end_pose_t     pose;
    } stim_row_t;

    localparam longint PI_FX      = 64'sd13493037705;
    localparam longint TWO_PI_FX  = 64'sd26986075409;
    localparam longint HALF_PI_FX = 64'sd6746518852;
    localparam longint GAIN_FX    = 64'sd652032874;
    localparam longint COORD_MAX  = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN  = -(64'sd1 <<< (COORD_W - 1));
    localparam int     RANDOM_REQUESTS = 1000;
    localparam int     WATCHDOG_LIMIT  = 2000;

    localparam longint ATAN_TAB [11] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
        64'sd16777131, 64'sd8388597, 64'sd4194303
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [HEAD_W-1:0]  start_heading;
    logic signed [CURV_W-1:0]  path_curvature;
    logic        [LEN_W-1:0]   arc_length;
    logic                      done;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [HEAD_W-1:0]  end_heading;
    logic                      out_of_range;

    // Typed expectation riding along with the request being driven.
    logic      row_typed;
    end_pose_t row_pose;

    end_pose_t pending_poses[$];
    stim_row_t stim_rows[$];
    int        fail_count;
    int        idle_cycles;

    arc_motion_end_pose u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_x        (start_x),
        .start_y        (start_y),
        .start_heading  (start_heading),
        .path_curvature (path_curvature),
        .arc_length     (arc_length),
        .done           (done),
        .end_x          (end_x),
        .end_y          (end_y),
        .end_heading    (end_heading),
        .out_of_range   (out_of_range)
    );

    // Clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Angle folded into [-pi, pi) in Q32.
    function automatic longint wrap_q32(input longint a);
        longint m;
        m = (a + PI_FX) % TWO_PI_FX;
        if (m < 0)
            m += TWO_PI_FX;
        return m - PI_FX;
    endfunction

    function automatic longint shift_round(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint divide_round(input longint n, input longint d);
        longint an;
        longint ad;
        longint q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (an + ad / 2) / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Rotation CORDIC, angle in Q32, cosine and sine in Q30.
    function automatic void cordic_sincos(input longint ang, output longint c,
                                          output longint s);
        longint px;
        longint py;
        longint nx;
        longint step;
        longint z;
        bit     flip;
        px = GAIN_FX;
        py = 0;
        flip = 1'b0;
        z = wrap_q32(ang);
        if (z > HALF_PI_FX)
        begin
            z -= PI_FX;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_FX)
        begin
            z += PI_FX;
            flip = 1'b1;
        end
        for (int i = 0; i < 32; i++)
        begin
            step = (i < 11) ? ATAN_TAB[i] : (64'sd1 <<< (32 - i));
            if (z >= 0)
            begin
                nx = px - (py >>> i);
                py = py + (px >>> i);
                z -= step;
            end
            else
            begin
                nx = px + (py >>> i);
                py = py - (px >>> i);
                z += step;
            end
            px = nx;
        end
        c = flip ? -px : px;
        s = flip ? -py : py;
    endfunction

    function automatic longint clamp_coord(input longint v, inout logic clipped);
        if (v > COORD_MAX)
        begin
            clipped = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            clipped = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // End pose reached by driving the arc.
    function automatic end_pose_t predict_end_pose(input pose_request_t r);
        end_pose_t p;
        longint    h32;
        longint    k;
        longint    len;
        longint    ch;
        longint    sh;
        longint    ce;
        longint    se;
        longint    e32;
        longint    dx;
        longint    dy;
        longint    head;
        logic      clipped;
        h32 = longint'(r.heading) * 65536;
        k = longint'(r.curvature);
        len = longint'({1'b0, r.length});
        clipped = 1'b0;
        cordic_sincos(h32, ch, sh);
        if (k == 0)
        begin
            dx = shift_round(len * ch, 30);
            dy = shift_round(len * sh, 30);
            head = longint'(r.heading);
        end
        else
        begin
            e32 = wrap_q32(h32 + len * k);
            cordic_sincos(e32, ce, se);
            dx = divide_round((se - sh) * 4, k);
            dy = divide_round((ch - ce) * 4, k);
            head = shift_round(e32, 16);
        end
        p.x = COORD_W'(clamp_coord(longint'(r.x) + dx, clipped));
        p.y = COORD_W'(clamp_coord(longint'(r.y) + dy, clipped));
        p.heading = HEAD_W'(head);
        p.clipped = clipped;
        return p;
    endfunction

    // Mostly well-scaled requests, some with every bit free.
    function automatic pose_request_t random_request();
        pose_request_t r;
        if ($urandom_range(9) < 7)
        begin
            r.x = COORD_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            r.y = COORD_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            r.heading = HEAD_W'(int'($urandom_range(0, 411775)) - 205888);
            r.curvature = ($urandom_range(9) == 0) ? '0 :
                CURV_W'(int'($urandom_range(0, 131072)) - 65536);
            r.length = LEN_W'($urandom_range(0, 1 << 20));
        end
        else
        begin
            r.x = COORD_W'($urandom);
            r.y = COORD_W'($urandom);
            r.heading = HEAD_W'($urandom);
            r.curvature = ($urandom_range(3) == 0) ? '0 : CURV_W'($urandom);
            r.length = LEN_W'($urandom);
        end
        return r;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input stim_row_t r);
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    // Drive one request, idling first at the given rate, and hold it until taken.
    task automatic send_request(input stim_row_t row, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        start_x        <= row.req.x;
        start_y        <= row.req.y;
        start_heading  <= row.req.heading;
        path_curvature <= row.req.curvature;
        arc_length     <= row.req.length;
        row_typed      <= row.typed;
        row_pose       <= row.pose;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Requests are logged on acceptance; results are checked against the oldest.
    always @(posedge clk)
    begin
        end_pose_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                pending_poses.insert(pending_poses.size(), row_typed ? row_pose :
                    predict_end_pose({start_x, start_y, start_heading,
                                      path_curvature, arc_length}));
            end
            if (done)
            begin
                if (pending_poses.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_poses.pop_front();
                    if (end_x !== want.x)
                    begin
                        $error("end_x expected %0d actual %0d", want.x, end_x);
                        fail_count++;
                    end
                    if (end_y !== want.y)
                    begin
                        $error("end_y expected %0d actual %0d", want.y, end_y);
                        fail_count++;
                    end
                    if (end_heading !== want.heading)
                    begin
                        $error("end_heading expected %0d actual %0d",
                               want.heading, end_heading);
                        fail_count++;
                    end
                    if (out_of_range !== want.clipped)
                    begin
                        $error("out_of_range expected %0b actual %0b",
                               want.clipped, out_of_range);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int        idle_pct;
        fail_count     = 0;
        idle_cycles    = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        start_x        = '0;
        start_y        = '0;
        start_heading  = '0;
        path_curvature = '0;
        arc_length     = '0;
        row_typed      = 1'b0;
        row_pose       = '0;

        // Directed table: typed rows have a zero length, so the pose stays put.
        add_row('{'{29'sd0, 29'sd0, 19'sd0, 18'sd0, 23'd0}, 1'b1,
                  '{29'sd0, 29'sd0, 19'sd0, 1'b0}});
        add_row('{'{29'sh0FFFFFFF, -29'sd268435456, 19'sh3FFFF, 18'sd0, 23'd0},
                  1'b1, '{29'sh0FFFFFFF, -29'sd268435456, 19'sh3FFFF, 1'b0}});
        add_row('{'{29'sd5, -29'sd7, -19'sd262144, 18'sd0, 23'd0}, 1'b1,
                  '{29'sd5, -29'sd7, -19'sd262144, 1'b0}});
        add_row('{'{29'sd100, 29'sd200, 19'sd1000, 18'sd65536, 23'd0}, 1'b1,
                  '{29'sd100, 29'sd200, 19'sd1000, 1'b0}});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, 18'sd0, 23'h7FFFFF}, 1'b0, '0});
        add_row('{'{29'sh0FFFFFFF, 29'sd0, 19'sd0, 18'sd0, 23'd4194304},
                  1'b0, '0});
        add_row('{'{-29'sd268435456, 29'sd0, 19'sd205887, 18'sd0, 23'd4194304},
                  1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, -19'sd205888, 18'sd65536, 23'd102944},
                  1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, -18'sd65536, 23'd4194304}, 1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, 18'sd1, 23'h7FFFFF}, 1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, -18'sd1, 23'd65536}, 1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, 18'sh1FFFF, 23'd65536}, 1'b0, '0});
        add_row('{'{29'sd0, 29'sd0, 19'sd0, -18'sd131072, 23'h7FFFFF}, 1'b0, '0});
        add_row('{'{29'sh0FFFFFFF, 29'sh0FFFFFFF, 19'sd102944, 18'sd1,
                    23'h7FFFFF}, 1'b0, '0});
        add_row('{'{29'sd1000, -29'sd1000, 19'sh3FFFF, 18'sd32768, 23'd300000},
                  1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_request(stim_rows[i], 12);

        // Random requests in three pacing phases.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            idle_pct = (n < RANDOM_REQUESTS / 3) ? 12 :
                       (n < 2 * RANDOM_REQUESTS / 3) ? 51 : 0;
            row.req = random_request();
            row.typed = 1'b0;
            row.pose = '0;
            send_request(row, idle_pct);
        end
        start <= 1'b0;

        // Drain, then leave room for any stray result.
        while (pending_poses.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
